/* rtl/ape_smr_pkg.sv */
// shared types and constants for the u(1) link smearing core
// no dependencies; used by every module of the block
package ape_smr_pkg;

	// item operation codes
	typedef enum logic [1:0] {
		OP_WRITE = 2'd0,
		OP_RUN   = 2'd1,
		OP_READ  = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	// configuration register indexes
	localparam logic [1:0] CFG_SIZE_X = 2'd0;
	localparam logic [1:0] CFG_SIZE_Y = 2'd1;
	localparam logic [1:0] CFG_SWEEPS = 2'd2;
	localparam logic [1:0] CFG_ALPHA  = 2'd3;

	localparam logic [6:0]  SIZE_X_RST = 7'd64;
	localparam logic [6:0]  SIZE_Y_RST = 7'd64;
	localparam logic [7:0]  SWEEPS_RST = 8'd1;
	localparam logic [15:0] ALPHA_RST  = 16'd16384;

	// sequencer step counter and its end points
	localparam int STEP_W = 4;
	localparam logic [STEP_W-1:0] SWEEP_LAST = 4'd11;
	localparam logic [STEP_W-1:0] COPY_LAST  = 4'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_SWEEP,
		ST_COPY,
		ST_DONE
	} state_t;

	typedef enum logic [1:0] {
		DM_IDLE,
		DM_SWEEP,
		DM_COPY
	} dp_mode_t;

	// controller to datapath
	typedef struct packed {
		dp_mode_t          mode;
		logic [STEP_W-1:0] step;
		logic              host_wr;
		logic              host_rd;
	} dp_cmd_t;

	// controller to output register
	typedef struct packed {
		logic load;
		logic done;
	} out_cmd_t;

endpackage

/* rtl/ape_smr_ctrl.sv */
// controller state machine: host transactions, sweep and copy sequencing
// depends on ape_smr_pkg
module ape_smr_ctrl #(
	parameter int MAX_X = 64,
	parameter int MAX_Y = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [1:0]                    operation,
	input  logic [$clog2(MAX_X+1)-1:0]    nx,
	input  logic [$clog2(MAX_Y+1)-1:0]    ny,
	input  logic [7:0]                    sweeps,
	input  logic                          out_free,
	output ape_smr_pkg::dp_cmd_t          cmd,
	output ape_smr_pkg::out_cmd_t         oc,
	output logic [$clog2(MAX_X)-1:0]      x,
	output logic [$clog2(MAX_Y)-1:0]      y
);
	localparam int XW  = $clog2(MAX_X);
	localparam int YW  = $clog2(MAX_Y);
	localparam int NXW = $clog2(MAX_X+1);
	localparam int NYW = $clog2(MAX_Y+1);

	ape_smr_pkg::state_t state_q, state_d;
	logic [ape_smr_pkg::STEP_W-1:0] step_q;
	logic [XW-1:0] x_q;
	logic [YW-1:0] y_q;
	logic [7:0] cnt_q;
	logic step_last, x_last, y_last, busy;

	assign x_last = (NXW'(x_q) == nx - NXW'(1));
	assign y_last = (NYW'(y_q) == ny - NYW'(1));
	assign busy = (state_q == ape_smr_pkg::ST_SWEEP) || (state_q == ape_smr_pkg::ST_COPY);
	assign step_last = (state_q == ape_smr_pkg::ST_SWEEP) ? (step_q == ape_smr_pkg::SWEEP_LAST)
		: (step_q == ape_smr_pkg::COPY_LAST);
	assign x = x_q;
	assign y = y_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ape_smr_pkg::ST_IDLE;
			step_q  <= '0;
			x_q     <= '0;
			y_q     <= '0;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (busy) begin
				if (step_last) begin
					step_q <= '0;
					if (y_last) begin
						y_q <= '0;
						x_q <= x_last ? '0 : x_q + XW'(1);
						if (x_last && state_q == ape_smr_pkg::ST_COPY) begin
							cnt_q <= (8'(cnt_q + 8'd1) == sweeps) ? 8'd0 : 8'(cnt_q + 8'd1);
						end
					end else begin
						y_q <= y_q + YW'(1);
					end
				end else begin
					step_q <= step_q + ape_smr_pkg::STEP_W'(1);
				end
			end
		end
	end

	always_comb begin
		state_d      = state_q;
		in_ready     = 1'b0;
		cmd.mode     = ape_smr_pkg::DM_IDLE;
		cmd.step     = step_q;
		cmd.host_wr  = 1'b0;
		cmd.host_rd  = 1'b0;
		oc.load      = 1'b0;
		oc.done      = 1'b0;
		unique case (state_q)
			ape_smr_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					unique case (ape_smr_pkg::op_t'(operation))
						ape_smr_pkg::OP_WRITE: cmd.host_wr = 1'b1;
						ape_smr_pkg::OP_READ: begin
							cmd.host_rd = 1'b1;
							state_d = ape_smr_pkg::ST_READ;
						end
						ape_smr_pkg::OP_RUN: begin
							state_d = (sweeps == 8'd0) ? ape_smr_pkg::ST_DONE
								: ape_smr_pkg::ST_SWEEP;
						end
						default: ;
					endcase
				end
			end
			ape_smr_pkg::ST_READ: begin
				if (out_free) begin
					oc.load = 1'b1;
					state_d = ape_smr_pkg::ST_IDLE;
				end
			end
			ape_smr_pkg::ST_DONE: begin
				if (out_free) begin
					oc.load = 1'b1;
					oc.done = 1'b1;
					state_d = ape_smr_pkg::ST_IDLE;
				end
			end
			ape_smr_pkg::ST_SWEEP: begin
				cmd.mode = ape_smr_pkg::DM_SWEEP;
				if (step_last && x_last && y_last) begin
					state_d = ape_smr_pkg::ST_COPY;
				end
			end
			ape_smr_pkg::ST_COPY: begin
				cmd.mode = ape_smr_pkg::DM_COPY;
				if (step_last && x_last && y_last) begin
					state_d = (8'(cnt_q + 8'd1) == sweeps) ? ape_smr_pkg::ST_DONE
						: ape_smr_pkg::ST_SWEEP;
				end
			end
			default: state_d = ape_smr_pkg::ST_IDLE;
		endcase
	end

endmodule

/* rtl/ape_smr_dp.sv */
// datapath: link and staple memories, staple accumulators, phase projection
// depends on ape_smr_pkg
module ape_smr_dp #(
	parameter int MAX_X      = 64,
	parameter int MAX_Y      = 64,
	parameter int PHASE_BITS = 16
) (
	input  logic                          clk,
	input  ape_smr_pkg::dp_cmd_t          cmd,
	input  logic [$clog2(MAX_X)-1:0]      x,
	input  logic [$clog2(MAX_Y)-1:0]      y,
	input  logic [$clog2(MAX_X+1)-1:0]    nx,
	input  logic [$clog2(MAX_Y+1)-1:0]    ny,
	input  logic [15:0]                   alpha,
	input  logic [5:0]                    site_x,
	input  logic [5:0]                    site_y,
	input  logic                          direction,
	input  logic [15:0]                   phase_in,
	output logic [15:0]                   rd_phase
);
	localparam int XW    = $clog2(MAX_X);
	localparam int YW    = $clog2(MAX_Y);
	localparam int NXW   = $clog2(MAX_X+1);
	localparam int NYW   = $clog2(MAX_Y+1);
	localparam int CXW   = (NXW > 6) ? NXW : 6;
	localparam int CYW   = (NYW > 6) ? NYW : 6;
	localparam int DEPTH = 2 * MAX_X * MAX_Y;
	localparam int AW    = $clog2(DEPTH);
	localparam int SW    = AW - 1;
	localparam int P     = PHASE_BITS;
	localparam logic [P-1:0] HALF = {1'b1, {(P-1){1'b0}}};

	logic [P-1:0] link_mem [DEPTH];
	logic [P-1:0] stap_mem [DEPTH];
	logic [P-1:0] link_rd_q, stap_rd_q;
	logic inside_q;
	logic [P-1:0] acc1_q, acc2_q, acc3_q, acc4_q;

	function automatic logic [AW-1:0] lidx(input logic [XW-1:0] cx, input logic [YW-1:0] cy,
		input logic mu);
		logic [SW-1:0] site;
		site = SW'(cy) * SW'(MAX_X) + SW'(cx);
		return {site, mu};
	endfunction

	// midpoint of two staples, floor halving of the signed difference
	function automatic logic [P-1:0] project(input logic [P-1:0] a, input logic [P-1:0] b,
		input logic az, input logic an);
		logic [P-1:0] d, h, m;
		d = b - a;
		h = {d[P-1], d[P-1:1]};
		m = a + h;
		if (an) m[P-1] = ~m[P-1];
		if (d == HALF || az) m = '0;
		return m;
	endfunction

	logic [XW-1:0] xp, xm, hx;
	logic [YW-1:0] yp, ym, hy;
	logic host_in;

	assign xp = (NXW'(x) == nx - NXW'(1)) ? '0 : x + XW'(1);
	assign xm = (x == '0) ? XW'(nx - NXW'(1)) : x - XW'(1);
	assign yp = (NYW'(y) == ny - NYW'(1)) ? '0 : y + YW'(1);
	assign ym = (y == '0) ? YW'(ny - NYW'(1)) : y - YW'(1);
	assign hx = XW'(site_x);
	assign hy = YW'(site_y);
	assign host_in = (CXW'(site_x) < CXW'(nx)) && (CYW'(site_y) < CYW'(ny));

	logic lrd_en, lwr_en, srd_en, swr_en;
	logic [AW-1:0] lrd_addr, lwr_addr, srd_addr, swr_addr;
	logic [P-1:0] lwr_data, swr_data;
	logic sweep_mode, copy_mode;

	assign sweep_mode = (cmd.mode == ape_smr_pkg::DM_SWEEP);
	assign copy_mode  = (cmd.mode == ape_smr_pkg::DM_COPY);

	// link read port: host read or the ten links around one site
	always_comb begin
		lrd_en   = 1'b0;
		lrd_addr = '0;
		if (cmd.host_rd) begin
			lrd_en   = 1'b1;
			lrd_addr = lidx(hx, hy, direction);
		end else if (sweep_mode) begin
			lrd_en = 1'b1;
			case (cmd.step)
				4'd0: lrd_addr = lidx(x, y, 1'b1);
				4'd1: lrd_addr = lidx(x, yp, 1'b0);
				4'd2: lrd_addr = lidx(xp, y, 1'b1);
				4'd3: lrd_addr = lidx(x, ym, 1'b0);
				4'd4: lrd_addr = lidx(xp, ym, 1'b1);
				4'd5: lrd_addr = lidx(x, ym, 1'b1);
				4'd6: lrd_addr = lidx(x, y, 1'b0);
				4'd7: lrd_addr = lidx(xm, y, 1'b1);
				4'd8: lrd_addr = lidx(xm, yp, 1'b0);
				4'd9: lrd_addr = lidx(xm, y, 1'b0);
				default: lrd_en = 1'b0;
			endcase
		end
	end

	// link write port: host write or copy back of the staple result
	always_comb begin
		lwr_en   = 1'b0;
		lwr_addr = lidx(hx, hy, direction);
		lwr_data = P'(phase_in);
		if (cmd.host_wr) begin
			lwr_en = host_in;
		end else if (copy_mode && cmd.step != 4'd0) begin
			lwr_en   = 1'b1;
			lwr_addr = lidx(x, y, cmd.step == ape_smr_pkg::COPY_LAST);
			lwr_data = stap_rd_q;
		end
	end

	always_comb begin
		srd_en   = copy_mode && (cmd.step != ape_smr_pkg::COPY_LAST);
		srd_addr = lidx(x, y, cmd.step[0]);
		swr_en   = sweep_mode && (cmd.step == 4'd7 || cmd.step == ape_smr_pkg::SWEEP_LAST);
		swr_addr = lidx(x, y, cmd.step == ape_smr_pkg::SWEEP_LAST);
		swr_data = (cmd.step == ape_smr_pkg::SWEEP_LAST)
			? project(acc3_q, acc4_q, alpha == 16'd0, alpha[15])
			: project(acc1_q, acc2_q, alpha == 16'd0, alpha[15]);
	end

	always_ff @(posedge clk) begin
		if (lwr_en) link_mem[lwr_addr] <= lwr_data;
		if (lrd_en) link_rd_q <= link_mem[lrd_addr];
		if (swr_en) stap_mem[swr_addr] <= swr_data;
		if (srd_en) stap_rd_q <= stap_mem[srd_addr];
		if (cmd.host_rd) inside_q <= host_in;
	end

	// staple sums; each capture takes the link read one step earlier
	always_ff @(posedge clk) begin
		if (sweep_mode) begin
			case (cmd.step)
				4'd1:  acc1_q <= link_rd_q;
				4'd2: begin
					acc1_q <= acc1_q + link_rd_q;
					acc3_q <= -link_rd_q;
				end
				4'd3: begin
					acc1_q <= acc1_q - link_rd_q;
					acc3_q <= acc3_q + link_rd_q;
				end
				4'd4:  acc2_q <= link_rd_q;
				4'd5:  acc2_q <= acc2_q + link_rd_q;
				4'd6:  acc2_q <= acc2_q - link_rd_q;
				4'd7:  acc3_q <= acc3_q + link_rd_q;
				4'd8:  acc4_q <= link_rd_q;
				4'd9:  acc4_q <= acc4_q + link_rd_q;
				4'd10: acc4_q <= acc4_q - link_rd_q;
				default: ;
			endcase
		end
	end

	assign rd_phase = inside_q ? 16'(link_rd_q) : 16'd0;

endmodule

/* rtl/u1_ape_link_smearing_core.sv */
// top level of the u(1) link smearing core: config registers, output register
// depends on ape_smr_pkg, ape_smr_ctrl, ape_smr_dp
//
// The core keeps a periodic 2d lattice of u(1) links as PHASE_BITS-bit phases
// in a single-port-read link memory, with a second memory of the same size
// holding the new phases of a sweep. A write transaction stores a link;
// in_ready stays high, so writes stream one per cycle. A read transaction
// registers the link memory read and drops in_ready until its result is
// loaded; the result sits in an output register, so the next item is taken
// while the result waits. A run transaction performs `sweeps` Jacobi sweeps:
// each site needs ten link reads through the one link read port, followed
// by a copy pass over every site from the staple memory back to the link
// memory. A run keeps in_ready low until the output register is free and it
// ends with one result carrying run_done. The user must write configuration
// only while idle; the block itself does not enforce it. Sizes of 0 act as 1
// and sizes beyond MAX_X or MAX_Y saturate. Links that were never written
// read back undefined.
module u1_ape_link_smearing_core #(
	parameter int MAX_X      = 64,
	parameter int MAX_Y      = 64,
	parameter int PHASE_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  operation,
	input  logic [5:0]  site_x,
	input  logic [5:0]  site_y,
	input  logic        direction,
	input  logic [15:0] phase_in,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] phase_out,
	output logic        run_done
);
	localparam int XW  = $clog2(MAX_X);
	localparam int YW  = $clog2(MAX_Y);
	localparam int NXW = $clog2(MAX_X+1);
	localparam int NYW = $clog2(MAX_Y+1);

	// configuration registers
	logic [6:0]  size_x_q, size_y_q;
	logic [7:0]  sweeps_q;
	logic [15:0] alpha_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_x_q <= ape_smr_pkg::SIZE_X_RST;
			size_y_q <= ape_smr_pkg::SIZE_Y_RST;
			sweeps_q <= ape_smr_pkg::SWEEPS_RST;
			alpha_q  <= ape_smr_pkg::ALPHA_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				ape_smr_pkg::CFG_SIZE_X: size_x_q <= cfg_data[6:0];
				ape_smr_pkg::CFG_SIZE_Y: size_y_q <= cfg_data[6:0];
				ape_smr_pkg::CFG_SWEEPS: sweeps_q <= cfg_data[7:0];
				ape_smr_pkg::CFG_ALPHA:  alpha_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// effective lattice extents
	logic [NXW-1:0] nx;
	logic [NYW-1:0] ny;

	always_comb begin
		if (size_x_q == 7'd0) nx = NXW'(1);
		else if (size_x_q > MAX_X) nx = NXW'(MAX_X);
		else nx = NXW'(size_x_q);
		if (size_y_q == 7'd0) ny = NYW'(1);
		else if (size_y_q > MAX_Y) ny = NYW'(MAX_Y);
		else ny = NYW'(size_y_q);
	end

	ape_smr_pkg::dp_cmd_t  cmd;
	ape_smr_pkg::out_cmd_t oc;
	logic [XW-1:0] cur_x;
	logic [YW-1:0] cur_y;
	logic [15:0]   rd_phase;
	logic          out_free;

	// output register, free when empty or being taken this cycle
	logic        out_valid_q;
	logic [15:0] phase_out_q;
	logic        run_done_q;

	assign out_free = !out_valid_q || out_ready;

	ape_smr_ctrl #(
		.MAX_X(MAX_X),
		.MAX_Y(MAX_Y)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.operation(operation),
		.nx       (nx),
		.ny       (ny),
		.sweeps   (sweeps_q),
		.out_free (out_free),
		.cmd      (cmd),
		.oc       (oc),
		.x        (cur_x),
		.y        (cur_y)
	);

	ape_smr_dp #(
		.MAX_X     (MAX_X),
		.MAX_Y     (MAX_Y),
		.PHASE_BITS(PHASE_BITS)
	) u_dp (
		.clk      (clk),
		.cmd      (cmd),
		.x        (cur_x),
		.y        (cur_y),
		.nx       (nx),
		.ny       (ny),
		.alpha    (alpha_q),
		.site_x   (site_x),
		.site_y   (site_y),
		.direction(direction),
		.phase_in (phase_in),
		.rd_phase (rd_phase)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (oc.load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// run results carry a zero phase
	always_ff @(posedge clk) begin
		if (oc.load) begin
			phase_out_q <= oc.done ? 16'd0 : rd_phase;
			run_done_q  <= oc.done;
		end
	end

	assign out_valid = out_valid_q;
	assign phase_out = phase_out_q;
	assign run_done  = run_done_q;

endmodule

/* rtl/ape_smr_chk.sv */
// port-level checker for the u(1) link smearing core, bound to the top level
// depends on ape_smr_pkg and u1_ape_link_smearing_core
module ape_smr_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic [1:0]  operation,
	input logic        out_valid,
	input logic        out_ready,
	input logic [15:0] phase_out,
	input logic        run_done
);

	// a pending result is not withdrawn
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped before transaction");

	// a pending result does not change
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(phase_out) && $stable(run_done))
		else $error("result changed while stalled");

	// run results carry no phase
	a_run_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && run_done |-> phase_out == 16'd0)
		else $error("run result with nonzero phase");

	// read and run transactions drop in_ready once they are taken
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (operation == ape_smr_pkg::OP_RUN
		|| operation == ape_smr_pkg::OP_READ) |=> !in_ready)
		else $error("input taken right after read or run");

endmodule

bind u1_ape_link_smearing_core ape_smr_chk u_chk (.*);
